/* rtl/core/next_line_prefetch_queue_macros.svh */
// ----------------------------------------------------------------------------
// next_line_prefetch_queue_macros
// Assertion macros shared by the prefetch queue checker.
// ----------------------------------------------------------------------------
`ifndef NEXT_LINE_PREFETCH_QUEUE_MACROS_SVH
`define NEXT_LINE_PREFETCH_QUEUE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define NLPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define NLPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/nlpq_pkg.sv */
// ----------------------------------------------------------------------------
// nlpq_pkg
// Types, constants and helpers for the next-line prefetch queue.
// ----------------------------------------------------------------------------
package nlpq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int ADDR_W      = 32;
  localparam int LINE_STRIDE = 32;
  localparam int BLOCK_SHIFT = 4;
  localparam int DEGREE      = 3;
  localparam int STEP_W      = $clog2(DEGREE);
  localparam int OCC_W       = 5;
  localparam int LCNT_W      = 2;

  // request opcodes
  localparam logic CMD_DEMAND = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] access_addr;
  } req_t;

  typedef struct packed {
    logic              pending;
    logic [ADDR_W-1:0] head_addr;
    logic [OCC_W-1:0]  occupancy;
    logic [LCNT_W-1:0] lines_queued;
    logic [LCNT_W-1:0] lines_dropped;
  } rsp_t;

  typedef struct packed {
    logic              capture;
    logic              enq;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

  // byte offset of prefetch candidate k (k = 0 -> +32)
  function automatic logic [ADDR_W-1:0] line_offset(logic [STEP_W-1:0] k);
    return ADDR_W'((int'(k) + 1) * LINE_STRIDE);
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

/* rtl/core/nlpq_ctrl.sv */
// ----------------------------------------------------------------------------
// nlpq_ctrl
// Sequencer: capture, three enqueue steps for a demand, result load.
// ----------------------------------------------------------------------------
module nlpq_ctrl
  import nlpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_cmd,
  input  ctl_sts_t sts,
  output ctl_cmd_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_OUT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  assign in_ready     = (state == S_IDLE);
  assign ctl.capture  = in_valid && in_ready;
  assign ctl.enq      = (state == S_ENQ);
  assign ctl.step     = step;
  assign ctl.out_load = (state == S_OUT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.capture) begin
            step  <= '0;
            state <= (in_cmd == CMD_POP) ? S_OUT : S_ENQ;
          end
        end
        S_ENQ: begin
          if (step == STEP_W'(DEGREE - 1)) begin
            state <= S_OUT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/nlpq_datapath.sv */
// ----------------------------------------------------------------------------
// nlpq_datapath
// Circular address queue, duplicate block scan and result register.
// ----------------------------------------------------------------------------
module nlpq_datapath
  import nlpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ctl_cmd_t ctl,
  output ctl_sts_t sts,
  input  req_t     in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output rsp_t     out_rsp
);

  logic [ADDR_W-1:0]      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       tail;
  logic [ADDR_W-1:0]      cur_addr;
  logic [DEGREE-1:0]      dup;
  logic [DEGREE-1:0]      dup_next;
  logic [QUEUE_DEPTH-1:0] in_range;
  logic [LCNT_W-1:0]      queued;
  logic [LCNT_W-1:0]      dropped;
  logic [ADDR_W-1:0]      cand;
  logic [CNT_W-1:0]       count;
  logic                   empty;
  logic                   full;

  assign empty = (head == tail);
  assign full  = (next_slot(tail) == head);
  assign cand  = cur_addr + line_offset(ctl.step);
  assign count = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                : ({1'b0, tail} + CNT_W'(QUEUE_DEPTH) - {1'b0, head});

  assign sts.out_free = !out_valid || out_ready;

  // live slots: head up to (not including) tail, wrapping
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (head <= tail) begin
        in_range[i] = (PTR_W'(i) >= head) && (PTR_W'(i) < tail);
      end else begin
        in_range[i] = (PTR_W'(i) >= head) || (PTR_W'(i) < tail);
      end
    end
  end

  // The three candidates sit in distinct blocks, so each is checked
  // against the queue as it stands before the access.
  always_comb begin
    logic [ADDR_W-1:0] c;
    logic              hit;
    c        = '0;
    hit      = 1'b0;
    dup_next = '0;
    for (int j = 0; j < DEGREE; j++) begin
      c   = in_req.access_addr + line_offset(STEP_W'(j));
      hit = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        hit = hit | (in_range[i] &&
              (entries[i][ADDR_W-1:BLOCK_SHIFT] == c[ADDR_W-1:BLOCK_SHIFT]));
      end
      dup_next[j] = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.capture && (in_req.cmd == CMD_POP) && !empty) begin
        head <= next_slot(head);
      end
      if (ctl.enq && !dup[ctl.step] && !full) begin
        tail <= next_slot(tail);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur_addr <= in_req.access_addr;
      dup      <= dup_next;
      queued   <= '0;
      dropped  <= '0;
    end
    if (ctl.enq && !dup[ctl.step]) begin
      if (full) begin
        dropped <= dropped + 1'b1;
      end else begin
        entries[tail] <= cand;
        queued        <= queued + 1'b1;
      end
    end
    if (ctl.out_load) begin
      out_rsp.pending       <= !empty;
      out_rsp.head_addr     <= empty ? '0 : entries[head];
      out_rsp.occupancy     <= OCC_W'(count);
      out_rsp.lines_queued  <= queued;
      out_rsp.lines_dropped <= dropped;
    end
  end

endmodule

/* rtl/core/next_line_prefetch_queue.sv */
// ----------------------------------------------------------------------------
// next_line_prefetch_queue
// Degree-3 next-line prefetcher with a circular request queue.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_req): cmd 0 is a demand access at
//   access_addr; the block tries to queue addr+32, +64 and +96 in order,
//   skipping any whose 16-byte block is already pending and dropping any
//   that finds the queue full (it holds QUEUE_DEPTH-1 addresses).
//   cmd 1 pops the head request; a pop on an empty queue does nothing.
// Output channel (out_valid/out_ready/out_rsp): one result per request,
//   showing pending, head address (0 when empty), occupancy and how many
//   lines this demand queued or dropped.
// Timing: the duplicate check against every live slot happens in the
//   accept cycle; for a demand the queue write port then takes one
//   candidate per cycle, and then the result register is loaded once
//   the receiver is free. A new request is taken in the cycle after the
//   result is loaded.
// The result register decouples the receiver: a new request is accepted
//   while the last result still waits; a stalled receiver only holds the
//   block in its result-load step.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module next_line_prefetch_queue
  import nlpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  // sequencer: owns request handshake and step count
  nlpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_req.cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  // queue storage, pointers, duplicate scan, result register
  nlpq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

/* rtl/core/nlpq_checker.sv */
// ----------------------------------------------------------------------------
// nlpq_checker
// Port-level checks on the prefetch queue results.
// ----------------------------------------------------------------------------
`include "next_line_prefetch_queue_macros.svh"

module nlpq_checker
  import nlpq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_rsp
);

  `NLPQ_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_rsp),
    "result changed while stalled")
  `NLPQ_ASSERT(a_empty_fields,
    out_valid && !out_rsp.pending |-> out_rsp.occupancy == '0 && out_rsp.head_addr == '0,
    "empty queue shows data")
  `NLPQ_ASSERT(a_pending_occ,
    out_valid && out_rsp.pending |-> out_rsp.occupancy != '0,
    "pending with zero occupancy")
  `NLPQ_ASSERT(a_line_total,
    out_valid |-> (3'(out_rsp.lines_queued) + 3'(out_rsp.lines_dropped)) <= 3'd3,
    "more than three lines counted")
  `NLPQ_ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind next_line_prefetch_queue nlpq_checker u_nlpq_checker (.*);

/* verif/next_line_prefetch_queue_tb.sv */
// ----------------------------------------------------------------------------
// next_line_prefetch_queue_tb
// Self-checking bench for the degree-3 next-line prefetch queue: directed
// corner requests, then random demand/pop traffic with random idling on both
// sides. A scoreboard class mirrors the queue and checks every status result.
// ----------------------------------------------------------------------------
module next_line_prefetch_queue_tb;
  import nlpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 21;      // percent of cycles a side idles
  localparam int RANDOM_ITEMS = 1326;    // after the directed requests
  localparam int CALM_FIRST   = 500;     // random window with no idling
  localparam int CALM_LAST    = 720;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;

  // --------------------------------------------------------------------------
  // Shadow of the prefetch queue; each accepted request yields one expected
  // status, checked in order against the block's results.
  // --------------------------------------------------------------------------
  class prefetch_scoreboard;
    logic [ADDR_W-1:0] slots[QUEUE_DEPTH];
    int unsigned       head;
    int unsigned       tail;
    rsp_t              status_due[$];
    int                errors;

    function new();
      head   = 0;
      tail   = 0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int unsigned live_count();
      return (tail >= head) ? tail - head : tail + QUEUE_DEPTH - head;
    endfunction

    // Scans head..tail, wrapping, for the same 16-byte block.
    function bit block_queued(logic [ADDR_W-1:0] addr);
      int unsigned p;
      p = head;
      for (int unsigned i = 0; i < live_count(); i++) begin
        if ((slots[p] >> BLOCK_SHIFT) == (addr >> BLOCK_SHIFT)) return 1'b1;
        p = (p + 1) % QUEUE_DEPTH;
      end
      return 1'b0;
    endfunction

    function void note_req(req_t r);
      rsp_t              s;
      logic [ADDR_W-1:0] cand;
      int unsigned       queued;
      int unsigned       dropped;
      int unsigned       occ;
      queued  = 0;
      dropped = 0;
      if (r.cmd == CMD_DEMAND) begin
        for (int k = 1; k <= DEGREE; k++) begin
          cand = r.access_addr + ADDR_W'(k * LINE_STRIDE);   // wraps mod 2^32
          if (block_queued(cand)) continue;                  // duplicate: no count
          if ((tail + 1) % QUEUE_DEPTH == head) begin
            dropped++;                                       // full
          end else begin
            slots[tail] = cand;
            tail        = (tail + 1) % QUEUE_DEPTH;
            queued++;
          end
        end
      end else if (head != tail) begin
        head = (head + 1) % QUEUE_DEPTH;                     // pop on empty: no-op
      end
      occ             = live_count();
      s.pending       = (occ != 0);
      s.head_addr     = (occ != 0) ? slots[head] : '0;
      s.occupancy     = OCC_W'(occ);
      s.lines_queued  = LCNT_W'(queued);
      s.lines_dropped = LCNT_W'(dropped);
      status_due.push_back(s);
    endfunction

    function void compare_field(string name, longint unsigned exp_v,
                                longint unsigned got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_v, got_v);
      end
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = status_due.pop_front();
      compare_field("pending",       want.pending,       got.pending);
      compare_field("head_addr",     want.head_addr,     got.head_addr);
      compare_field("occupancy",     want.occupancy,     got.occupancy);
      compare_field("lines_queued",  want.lines_queued,  got.lines_queued);
      compare_field("lines_dropped", want.lines_dropped, got.lines_dropped);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  prefetch_scoreboard sb;
  bit                 calm;       // both sides stop idling while set
  int unsigned        cycles;

  next_line_prefetch_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random backpressure, changed at the falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_req(in_req);
    if (!rst && out_valid && out_ready) sb.check_rsp(out_rsp);
  end

  // Run guard: a hang or lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it. Idle gaps
  // are inserted before valid rises, never while it is up.
  task automatic send_req(input logic cmd, input logic [ADDR_W-1:0] addr);
    req_t r;
    r.cmd         = cmd;
    r.access_addr = addr;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic demand(input logic [ADDR_W-1:0] addr);
    send_req(CMD_DEMAND, addr);
  endtask

  task automatic pop();
    send_req(CMD_POP, ADDR_W'($urandom));   // address is ignored on a pop
  endtask

  // Random traffic in phases of varying pop rate so the queue fills, sits
  // full, drains and sits empty. Addresses mix streams, clustered accesses
  // (duplicate blocks), fully random values and values near the 2^32 wrap.
  task automatic random_traffic();
    int                pop_pct;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] addr;
    int                pick;
    pop_pct = 30;
    base    = ADDR_W'($urandom);
    last    = base;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n % 90 == 0) begin
        case ($urandom_range(4))
          0: pop_pct = 5;
          1: pop_pct = 25;
          2: pop_pct = 40;
          3: pop_pct = 60;
          default: pop_pct = 85;
        endcase
      end
      if ($urandom_range(99) < pop_pct) begin
        pop();
      end else begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          addr = last + ADDR_W'(LINE_STRIDE);                 // sequential stream
        end else if (pick < 55) begin
          addr = base + ADDR_W'($urandom_range(0, 255));      // same neighborhood
        end else if (pick < 65) begin
          addr = 32'hFFFF_FF00 + ADDR_W'($urandom_range(0, 255));
          base = addr;
        end else begin
          addr = ADDR_W'($urandom);
          base = addr;
        end
        last = addr;
        demand(addr);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    sb       = new();
    calm     = 1'b0;
    cycles   = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_req   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: pop on empty, duplicates, address wrap, full queue, drain.
    pop();
    demand(32'h0000_0000);          // queues 32, 64, 96
    demand(32'h0000_0000);          // all three already pending
    demand(32'h0000_0005);          // same blocks at a byte offset
    demand(32'h0000_0010);          // new blocks between the old ones
    demand(32'hFFFF_FFFF);          // candidates wrap past zero, two dups
    demand(32'hFFFF_FFC0);          // wrap lands on block zero
    pop();
    for (int i = 0; i < 9; i++) begin
      demand(32'h8000_0000 + ADDR_W'(i * 32'h1000));   // fills, then drops
    end
    demand(32'h7FFF_FFFF);          // full: all three dropped
    repeat (4) pop();
    demand(32'hAAAA_AAAA);
    demand(32'h5555_5555);

    random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/nlpq_pkg.sv
rtl/core/nlpq_ctrl.sv
rtl/core/nlpq_datapath.sv
rtl/core/next_line_prefetch_queue.sv
rtl/core/nlpq_checker.sv
verif/next_line_prefetch_queue_tb.sv
